// File: hw/rtl/leo_pkg.sv
// ---------------------------------------------------------------------------
// leo_pkg
// Shared types, codes and fixed-point helpers of the Lorenz Euler oscillator.
// ---------------------------------------------------------------------------
`default_nettype none

package leo_pkg;

   localparam int QW = 32;
   localparam int PW = 2 * QW;
   localparam int QFRAC = 24;
   localparam int CSR_IW = 2;

   typedef logic signed [QW-1:0] q_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic [CSR_IW-1:0] csr_index_type;

   localparam q_type Q_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam q_type Q_MIN = {1'b1, {(QW-1){1'b0}}};

   // 0.1 in q8.24
   localparam q_type INIT_X_RESET = 32'sd1677722;
   localparam q_type INIT_Y_RESET = 32'sd0;
   localparam q_type INIT_Z_RESET = 32'sd0;

   localparam csr_index_type CSR_INIT_X = 2'd0;
   localparam csr_index_type CSR_INIT_Y = 2'd1;
   localparam csr_index_type CSR_INIT_Z = 2'd2;

   localparam logic [3:0] STEP_LAST = 4'd9;

   typedef enum logic [3:0] {
      SRC_X, SRC_Y, SRC_Z, SRC_H, SRC_A, SRC_B, SRC_C,
      SRC_TA, SRC_TB, SRC_TC, SRC_TD
   } src_sel_type;

   typedef enum logic [2:0] {
      DST_TA, DST_TB, DST_TC, DST_TD, DST_PX, DST_PY, DST_PZ
   } dst_sel_type;

   typedef enum logic {
      ALU_ADD, ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic        load_req;
      logic        load_rsp;
      logic        mul_en;
      src_sel_type mul_a;
      src_sel_type mul_b;
      logic        rnd_en;
      dst_sel_type rnd_dst;
      logic        alu_en;
      alu_op_type  alu_op;
      src_sel_type alu_a;
      src_sel_type alu_b;
      dst_sel_type alu_dst;
   } dp_cmd_type;

   // round half up, drop fraction bits, saturate
   function automatic q_type q_round(input prod_type p);
      prod_type r;
      r = p + (prod_type'(1) <<< (QFRAC - 1));
      if (r[PW-1:QFRAC+QW-1] == {(PW-QFRAC-QW+1){r[PW-1]}}) begin
         return r[QFRAC+QW-1:QFRAC];
      end else if (r[PW-1]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

   function automatic q_type q_addsub(input q_type a, input q_type b, input alu_op_type op);
      logic signed [QW:0] s;
      if (op == ALU_SUB) begin
         s = {a[QW-1], a} - {b[QW-1], b};
      end else begin
         s = {a[QW-1], a} + {b[QW-1], b};
      end
      if (s[QW] != s[QW-1]) begin
         return s[QW] ? Q_MIN : Q_MAX;
      end else begin
         return s[QW-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/leo_ctrl.sv
// ---------------------------------------------------------------------------
// leo_ctrl
// Sequencer: accepts a request, issues the ten datapath steps of one Euler
// update and hands the new point to the response register.
// ---------------------------------------------------------------------------
`default_nettype none

module leo_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output leo_pkg::dp_cmd_type  cmd
);
   import leo_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
               step_in  = '0;
            end
         end
         ST_RUN: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // step schedule: multiply, round of the previous product, one add/sub
   always_comb begin
      cmd          = '0;
      cmd.mul_a    = SRC_X;
      cmd.mul_b    = SRC_X;
      cmd.rnd_dst  = DST_TA;
      cmd.alu_op   = ALU_ADD;
      cmd.alu_a    = SRC_X;
      cmd.alu_b    = SRC_X;
      cmd.alu_dst  = DST_TA;
      cmd.load_req = req_take;
      cmd.load_rsp = (state_ff == ST_DONE) && rsp_free;
      if (state_ff == ST_RUN) begin
         unique case (step_ff)
            4'd0: begin
               cmd.mul_en = 1'b1; cmd.mul_a = SRC_H; cmd.mul_b = SRC_A;
               cmd.alu_en = 1'b1; cmd.alu_op = ALU_SUB;
               cmd.alu_a = SRC_Y; cmd.alu_b = SRC_X; cmd.alu_dst = DST_TA;
            end
            4'd1: begin
               cmd.rnd_en = 1'b1; cmd.rnd_dst = DST_TB;
               cmd.mul_en = 1'b1; cmd.mul_a = SRC_X; cmd.mul_b = SRC_Y;
               cmd.alu_en = 1'b1; cmd.alu_op = ALU_SUB;
               cmd.alu_a = SRC_B; cmd.alu_b = SRC_Z; cmd.alu_dst = DST_TC;
            end
            4'd2: begin
               cmd.rnd_en = 1'b1; cmd.rnd_dst = DST_TD;
               cmd.mul_en = 1'b1; cmd.mul_a = SRC_TB; cmd.mul_b = SRC_TA;
            end
            4'd3: begin
               cmd.rnd_en = 1'b1; cmd.rnd_dst = DST_TB;
               cmd.mul_en = 1'b1; cmd.mul_a = SRC_X; cmd.mul_b = SRC_TC;
            end
            4'd4: begin
               cmd.rnd_en = 1'b1; cmd.rnd_dst = DST_TA;
               cmd.mul_en = 1'b1; cmd.mul_a = SRC_C; cmd.mul_b = SRC_Z;
               cmd.alu_en = 1'b1; cmd.alu_op = ALU_ADD;
               cmd.alu_a = SRC_X; cmd.alu_b = SRC_TB; cmd.alu_dst = DST_PX;
            end
            4'd5: begin
               cmd.rnd_en = 1'b1; cmd.rnd_dst = DST_TC;
               cmd.alu_en = 1'b1; cmd.alu_op = ALU_SUB;
               cmd.alu_a = SRC_TA; cmd.alu_b = SRC_Y; cmd.alu_dst = DST_TA;
            end
            4'd6: begin
               cmd.mul_en = 1'b1; cmd.mul_a = SRC_H; cmd.mul_b = SRC_TA;
               cmd.alu_en = 1'b1; cmd.alu_op = ALU_SUB;
               cmd.alu_a = SRC_TD; cmd.alu_b = SRC_TC; cmd.alu_dst = DST_TC;
            end
            4'd7: begin
               cmd.rnd_en = 1'b1; cmd.rnd_dst = DST_TA;
               cmd.mul_en = 1'b1; cmd.mul_a = SRC_H; cmd.mul_b = SRC_TC;
            end
            4'd8: begin
               cmd.rnd_en = 1'b1; cmd.rnd_dst = DST_TB;
               cmd.alu_en = 1'b1; cmd.alu_op = ALU_ADD;
               cmd.alu_a = SRC_Y; cmd.alu_b = SRC_TA; cmd.alu_dst = DST_PY;
            end
            4'd9: begin
               cmd.alu_en = 1'b1; cmd.alu_op = ALU_ADD;
               cmd.alu_a = SRC_Z; cmd.alu_b = SRC_TB; cmd.alu_dst = DST_PZ;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/leo_datapath.sv
// ---------------------------------------------------------------------------
// leo_datapath
// Point registers, operand latches, one shared 32x32 multiplier with a
// rounding stage, a saturating adder and the response registers.
// ---------------------------------------------------------------------------
`default_nettype none

module leo_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire leo_pkg::dp_cmd_type    cmd,
   input  wire logic                   csr_wr_en,
   input  wire leo_pkg::csr_index_type csr_index,
   input  wire leo_pkg::q_type         csr_wdata,
   input  wire leo_pkg::q_type         req_step_size,
   input  wire leo_pkg::q_type         req_sigma,
   input  wire leo_pkg::q_type         req_rho,
   input  wire leo_pkg::q_type         req_beta,
   output leo_pkg::q_type              rsp_new_x,
   output leo_pkg::q_type              rsp_new_y,
   output leo_pkg::q_type              rsp_new_z
);
   import leo_pkg::*;

   q_type pos_x_ff, pos_x_in;
   q_type pos_y_ff, pos_y_in;
   q_type pos_z_ff, pos_z_in;
   q_type h_ff, a_ff, b_ff, c_ff;
   q_type ta_ff, ta_in, tb_ff, tb_in, tc_ff, tc_in, td_ff, td_in;
   q_type new_x_ff, new_y_ff, new_z_ff;
   prod_type prod_ff, prod_in;
   q_type mul_a, mul_b, alu_a, alu_b;
   q_type rnd_q, alu_q;

   function automatic q_type pick(
      input src_sel_type sel,
      input q_type x, input q_type y, input q_type z,
      input q_type h, input q_type a, input q_type b, input q_type c,
      input q_type ta, input q_type tb, input q_type tc, input q_type td
   );
      q_type v;
      unique case (sel)
         SRC_X:   v = x;
         SRC_Y:   v = y;
         SRC_Z:   v = z;
         SRC_H:   v = h;
         SRC_A:   v = a;
         SRC_B:   v = b;
         SRC_C:   v = c;
         SRC_TA:  v = ta;
         SRC_TB:  v = tb;
         SRC_TC:  v = tc;
         SRC_TD:  v = td;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign mul_a = pick(cmd.mul_a, pos_x_ff, pos_y_ff, pos_z_ff, h_ff, a_ff, b_ff, c_ff,
                       ta_ff, tb_ff, tc_ff, td_ff);
   assign mul_b = pick(cmd.mul_b, pos_x_ff, pos_y_ff, pos_z_ff, h_ff, a_ff, b_ff, c_ff,
                       ta_ff, tb_ff, tc_ff, td_ff);
   assign alu_a = pick(cmd.alu_a, pos_x_ff, pos_y_ff, pos_z_ff, h_ff, a_ff, b_ff, c_ff,
                       ta_ff, tb_ff, tc_ff, td_ff);
   assign alu_b = pick(cmd.alu_b, pos_x_ff, pos_y_ff, pos_z_ff, h_ff, a_ff, b_ff, c_ff,
                       ta_ff, tb_ff, tc_ff, td_ff);

   assign prod_in = prod_type'(mul_a) * prod_type'(mul_b);
   assign rnd_q   = q_round(prod_ff);
   assign alu_q   = q_addsub(alu_a, alu_b, cmd.alu_op);

   always_comb begin
      ta_in = ta_ff;
      tb_in = tb_ff;
      tc_in = tc_ff;
      td_in = td_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (cmd.rnd_en) begin
         unique case (cmd.rnd_dst)
            DST_TA:  ta_in = rnd_q;
            DST_TB:  tb_in = rnd_q;
            DST_TC:  tc_in = rnd_q;
            DST_TD:  td_in = rnd_q;
            default: begin
            end
         endcase
      end
      if (cmd.alu_en) begin
         unique case (cmd.alu_dst)
            DST_TA:  ta_in = alu_q;
            DST_TB:  tb_in = alu_q;
            DST_TC:  tc_in = alu_q;
            DST_TD:  td_in = alu_q;
            DST_PX:  pos_x_in = alu_q;
            DST_PY:  pos_y_in = alu_q;
            DST_PZ:  pos_z_in = alu_q;
            default: begin
            end
         endcase
      end
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INIT_X: pos_x_in = csr_wdata;
            CSR_INIT_Y: pos_y_in = csr_wdata;
            CSR_INIT_Z: pos_z_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= INIT_X_RESET;
         pos_y_ff <= INIT_Y_RESET;
         pos_z_ff <= INIT_Z_RESET;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         pos_z_ff <= pos_z_in;
      end
   end

   always_ff @(posedge clock) begin
      ta_ff <= ta_in;
      tb_ff <= tb_in;
      tc_ff <= tc_in;
      td_ff <= td_in;
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_req) begin
         h_ff <= req_step_size;
         a_ff <= req_sigma;
         b_ff <= req_rho;
         c_ff <= req_beta;
      end
      if (cmd.load_rsp) begin
         new_x_ff <= pos_x_ff;
         new_y_ff <= pos_y_ff;
         new_z_ff <= pos_z_ff;
      end
   end

   assign rsp_new_x = new_x_ff;
   assign rsp_new_y = new_y_ff;
   assign rsp_new_z = new_z_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lorenz_euler_oscillator_unit.sv
// ---------------------------------------------------------------------------
// lorenz_euler_oscillator_unit
// Lorenz attractor oscillator advancing x, y, z by one forward Euler step
// per request, signed q8.24 with saturation.
// ---------------------------------------------------------------------------
// Each request (step size, sigma, rho, beta) advances the held point by one
// Euler step and returns the new x, y, z as one response. No new request is
// taken until the last one is done: one shared 32x32 multiplier runs the
// seven products over ten sequencer steps, then the done state moves the
// point into the response register when it is free. A finished response may
// wait under stall while the next request is already being worked on; a
// second finished point waits until the first response is taken. Writing
// csr index 0, 1 or 2 loads that coordinate of the point directly; writes
// belong in idle periods only.
`default_nettype none

module lorenz_euler_oscillator_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire leo_pkg::q_type         req_step_size,
   input  wire leo_pkg::q_type         req_sigma,
   input  wire leo_pkg::q_type         req_rho,
   input  wire leo_pkg::q_type         req_beta,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output leo_pkg::q_type              rsp_new_x,
   output leo_pkg::q_type              rsp_new_y,
   output leo_pkg::q_type              rsp_new_z,
   input  wire logic                   csr_wr_en,
   input  wire leo_pkg::csr_index_type csr_index,
   input  wire leo_pkg::q_type         csr_wdata
);
   import leo_pkg::*;

   dp_cmd_type cmd;

   leo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   leo_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_step_size (req_step_size),
      .req_sigma     (req_sigma),
      .req_rho       (req_rho),
      .req_beta      (req_beta),
      .rsp_new_x     (rsp_new_x),
      .rsp_new_y     (rsp_new_y),
      .rsp_new_z     (rsp_new_z)
   );

endmodule

`default_nettype wire

// File: hw/rtl/leo_checker.sv
// ---------------------------------------------------------------------------
// leo_checker
// Port-level checks of the oscillator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module leo_checker (
   input wire logic           clock,
   input wire logic           reset,
   input wire logic           req_valid,
   input wire logic           req_stall,
   input wire logic           rsp_valid,
   input wire logic           rsp_stall,
   input wire leo_pkg::q_type rsp_new_x,
   input wire leo_pkg::q_type rsp_new_y,
   input wire leo_pkg::q_type rsp_new_z
);

   // a taken request blocks the next one until its step is done
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous step still running");

   // a new response appears only as the sequencer returns to idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("response raised while sequencer busy");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_x)
         && $stable(rsp_new_y) && $stable(rsp_new_z))
      else $error("stalled response changed");

endmodule

bind lorenz_euler_oscillator_unit leo_checker u_leo_checker (.*);

`default_nettype wire
